// File: hdl/nrfp_pkg.sv
// shared types, state codes and status codes of the reply frame parser
package nrfp_pkg;

	// parse phase codes
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_PRE1  = 4'd1;
	localparam logic [3:0] PH_PRE2  = 4'd2;
	localparam logic [3:0] PH_CODE1 = 4'd3;
	localparam logic [3:0] PH_CODE2 = 4'd4;
	localparam logic [3:0] PH_ERRF  = 4'd5;
	localparam logic [3:0] PH_EXTH  = 4'd6;
	localparam logic [3:0] PH_EXTL  = 4'd7;
	localparam logic [3:0] PH_EXTCS = 4'd8;
	localparam logic [3:0] PH_TFI   = 4'd9;
	localparam logic [3:0] PH_CC    = 4'd10;
	localparam logic [3:0] PH_DATA  = 4'd11;
	localparam logic [3:0] PH_DCS   = 4'd12;
	localparam logic [3:0] PH_POST  = 4'd13;

	// frame status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_PREAMBLE  = 4'd1;
	localparam logic [3:0] ST_ERR_FRAME = 4'd2;
	localparam logic [3:0] ST_LEN_CSUM  = 4'd3;
	localparam logic [3:0] ST_BAD_LEN   = 4'd4;
	localparam logic [3:0] ST_TYPE      = 4'd5;
	localparam logic [3:0] ST_RESP_CODE = 4'd6;
	localparam logic [3:0] ST_DATA_CSUM = 4'd7;
	localparam logic [3:0] ST_POSTAMBLE = 4'd8;

	// frame bytes
	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] BYTE_FF    = 8'hFF;
	localparam logic [7:0] BYTE_ERR   = 8'h01;
	localparam logic [7:0] BYTE_TYPE  = 8'hD5;

	// register map
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_EXP_CMD = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;
	localparam logic [7:0]  EXP_CMD_RESET = 8'd0;
	localparam logic [15:0] MAX_LEN_RESET = 16'd264;

	// output word: tdata width
	localparam int unsigned OUT_DATA_W = 32;

	// one result word
	typedef struct packed {
		logic        is_payload;
		logic [7:0]  payload_byte;
		logic        frame_done;
		logic [3:0]  status;
		logic [15:0] frame_length;
	} nrfp_res_t;

endpackage

// File: hdl/nrfp_parser.sv
// byte-wise frame parsing state machine, one byte per cycle while bytes are accepted
module nrfp_parser
	import nrfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic        frame_start,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  exp_cmd,
	input  logic [15:0] max_len,
	output logic        res_valid,
	output nrfp_res_t   res
);

	logic [3:0]  ph_q, ph_d;
	logic [7:0]  hdr_q, hdr_d;
	logic [7:0]  lenh_q, lenh_d;
	logic [15:0] plen_q, plen_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  dcs_q, dcs_d;

	logic [15:0] len_all;
	logic [15:0] len_m2;
	logic        len_short;
	logic        len_long;
	logic [15:0] left_dec;
	logic [8:0]  resp_exp;

	// shared length check for normal and extended frames
	always_comb begin
		len_all = (ph_q == PH_EXTCS) ? {lenh_q, hdr_q} : {8'd0, hdr_q};
		len_m2 = len_all - 16'd2;
		len_short = (len_all < 16'd2);
		len_long = (len_m2 > max_len);
		left_dec = left_q - 16'd1;
		resp_exp = {1'b0, exp_cmd} + 9'd1;
	end

	// next state and result
	always_comb begin
		ph_d = ph_q;
		hdr_d = hdr_q;
		lenh_d = lenh_q;
		plen_d = plen_q;
		left_d = left_q;
		dcs_d = dcs_q;
		res_valid = 1'b0;
		res = '0;
		if (frame_start) begin
			ph_d = PH_PRE1;
			hdr_d = '0;
			lenh_d = '0;
			plen_d = '0;
			left_d = '0;
			dcs_d = '0;
			if (rx_byte != BYTE_ZERO) begin
				res_valid = 1'b1;
				res.frame_done = 1'b1;
				res.status = ST_PREAMBLE;
				ph_d = PH_IDLE;
			end
		end else begin
			unique case (ph_q)
				PH_PRE1: begin
					if (rx_byte == BYTE_FF) begin
						ph_d = PH_CODE1;
					end else if (rx_byte == BYTE_ZERO) begin
						ph_d = PH_PRE2;
					end else begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_PREAMBLE;
						ph_d = PH_IDLE;
					end
				end
				PH_PRE2: begin
					if (rx_byte == BYTE_FF) begin
						ph_d = PH_CODE1;
					end else begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_PREAMBLE;
						ph_d = PH_IDLE;
					end
				end
				PH_CODE1: begin
					hdr_d = rx_byte;
					ph_d = PH_CODE2;
				end
				PH_CODE2: begin
					hdr_d = rx_byte;
					if (hdr_q == BYTE_ERR && rx_byte == BYTE_FF) begin
						left_d = 16'd3;
						ph_d = PH_ERRF;
					end else if (hdr_q == BYTE_FF && rx_byte == BYTE_FF) begin
						ph_d = PH_EXTH;
					end else if (({1'b0, hdr_q} + {1'b0, rx_byte}) != 9'h100) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_LEN_CSUM;
						ph_d = PH_IDLE;
					end else if (len_short) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_BAD_LEN;
						ph_d = PH_IDLE;
					end else if (len_long) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_BAD_LEN;
						res.frame_length = len_m2;
						ph_d = PH_IDLE;
					end else begin
						plen_d = len_m2;
						ph_d = PH_TFI;
					end
				end
				PH_ERRF: begin
					left_d = left_dec;
					if (left_dec == 16'd0) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_ERR_FRAME;
						ph_d = PH_IDLE;
					end
				end
				PH_EXTH: begin
					lenh_d = rx_byte;
					ph_d = PH_EXTL;
				end
				PH_EXTL: begin
					hdr_d = rx_byte;
					ph_d = PH_EXTCS;
				end
				PH_EXTCS: begin
					if ((lenh_q + hdr_q + rx_byte) != 8'd0) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_LEN_CSUM;
						ph_d = PH_IDLE;
					end else if (len_short) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_BAD_LEN;
						ph_d = PH_IDLE;
					end else if (len_long) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_BAD_LEN;
						res.frame_length = len_m2;
						ph_d = PH_IDLE;
					end else begin
						plen_d = len_m2;
						ph_d = PH_TFI;
					end
				end
				PH_TFI: begin
					if (rx_byte != BYTE_TYPE) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_TYPE;
						res.frame_length = plen_q;
						ph_d = PH_IDLE;
					end else begin
						dcs_d = BYTE_TYPE;
						ph_d = PH_CC;
					end
				end
				PH_CC: begin
					if ({1'b0, rx_byte} != resp_exp) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_RESP_CODE;
						res.frame_length = plen_q;
						ph_d = PH_IDLE;
					end else begin
						dcs_d = dcs_q + rx_byte;
						if (plen_q == 16'd0) begin
							ph_d = PH_DCS;
						end else begin
							left_d = plen_q;
							ph_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					dcs_d = dcs_q + rx_byte;
					left_d = left_dec;
					if (left_dec == 16'd0) begin
						ph_d = PH_DCS;
					end
					res_valid = 1'b1;
					res.is_payload = 1'b1;
					res.payload_byte = rx_byte;
				end
				PH_DCS: begin
					if ((dcs_q + rx_byte) != 8'd0) begin
						res_valid = 1'b1;
						res.frame_done = 1'b1;
						res.status = ST_DATA_CSUM;
						res.frame_length = plen_q;
						ph_d = PH_IDLE;
					end else begin
						ph_d = PH_POST;
					end
				end
				PH_POST: begin
					res_valid = 1'b1;
					res.frame_done = 1'b1;
					res.status = (rx_byte == BYTE_ZERO) ? ST_OK : ST_POSTAMBLE;
					res.frame_length = plen_q;
					ph_d = PH_IDLE;
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end
	end

	// state registers, updated on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			hdr_q <= '0;
			lenh_q <= '0;
			plen_q <= '0;
			left_q <= '0;
			dcs_q <= '0;
		end else if (take) begin
			ph_q <= ph_d;
			hdr_q <= hdr_d;
			lenh_q <= lenh_d;
			plen_q <= plen_d;
			left_q <= left_d;
			dcs_q <= dcs_d;
		end
	end

endmodule

// File: hdl/nrfp_out_reg.sv
// result register between the parser and the master side
module nrfp_out_reg
	import nrfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  nrfp_res_t res_in,
	input  logic      drain,
	output logic      ready,
	output logic      valid,
	output nrfp_res_t res_out
);

	logic      valid_q;
	nrfp_res_t res_q;

	// room when empty or when the held word leaves this cycle
	assign ready = !valid_q || drain;
	assign valid = valid_q;
	assign res_out = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (drain) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: hdl/nfc_reply_frame_parser_top.sv
// Reply frame parser for a reader chip: byte stream in, payload and status out.
//
// Slave side: one reply byte per word on s_tdata, s_tuser high on the first
// byte read after the chip signals ready (restarts any frame in progress).
// Master side: one word per payload byte (m_tuser high) and one word that
// ends each frame (m_tlast high) carrying status and payload length.
// Header, checksum and ignored bytes give no output word.
// A result is registered and appears on the master side in the cycle after the byte
// that causes it is accepted. Throughput: one byte per cycle while m_tready is high, set by the
// parse state machine and the one-entry result register.
// When the receiver stalls, the result register holds its word and s_tready
// drops only while that register is full and not being drained.
// Config: APB port, register 0 expected command at 0x0, register 1 maximum
// payload length at 0x4; write them only while the parser is idle.
// Reset: arst_n clears the parse state to idle, empties the result register
// and sets expected command 0, maximum payload length 264.
module nfc_reply_frame_parser_top
	import nrfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  logic                  s_tuser,   // [0] frame_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [7:0] payload_byte, [11:8] status, [27:12] frame_length, [31:28] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,   // [0] is_payload
	output logic                  m_tlast,   // frame_done
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [7:0]  exp_cmd_q;
	logic [15:0] max_len_q;
	logic        cfg_wr;
	logic        take;
	logic        res_valid;
	nrfp_res_t   res;
	nrfp_res_t   res_out;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= EXP_CMD_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_EXP_CMD: exp_cmd_q <= pwdata[7:0];
				REG_MAX_LEN: max_len_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_EXP_CMD: prdata = {24'd0, exp_cmd_q};
			REG_MAX_LEN: prdata = {16'd0, max_len_q};
			default:     prdata = '0;
		endcase
	end

	assign take = s_tvalid && s_tready;

	nrfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.frame_start(s_tuser),
		.rx_byte    (s_tdata),
		.exp_cmd    (exp_cmd_q),
		.max_len    (max_len_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	nrfp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take && res_valid),
		.res_in (res),
		.drain  (m_tready),
		.ready  (s_tready),
		.valid  (m_tvalid),
		.res_out(res_out)
	);

	// output word packing
	assign m_tdata = {4'd0, res_out.frame_length, res_out.status, res_out.payload_byte};
	assign m_tuser = res_out.is_payload;
	assign m_tlast = res_out.frame_done;

endmodule

// File: hdl/nrfp_checker.sv
// port-level checks of the reply frame parser, bound to the top level
module nrfp_checker
	import nrfp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser,
	input logic                  m_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// every word is either a payload byte or a frame end, never both
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != m_tlast))
		else $error("output word kind invalid");

	// payload words carry no status and no length
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[27:8] == 20'd0)
		else $error("payload word carries status or length");

	// an empty result register always takes input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// status codes stay in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[11:8] <= ST_POSTAMBLE)
		else $error("status code out of range");

endmodule

bind nfc_reply_frame_parser_top nrfp_checker u_nrfp_checker (.*);

// File: verif/nfc_reply_frame_parser_top_tb.sv
// self-checking testbench of the reply frame parser: framed byte traffic, stalls, register setup
module nfc_reply_frame_parser_top_tb;
	import nrfp_pkg::*;

	// ways a generated reply frame can be broken
	typedef enum int {FL_NONE, FL_TYPE, FL_CODE, FL_DCS, FL_POST, FL_LCS} flaw_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // [7:0] rx_byte
	logic                  s_tuser = 1'b0; // [0] frame_start
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [7:0] payload_byte, [11:8] status, [27:12] frame_length, [31:28] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;        // [0] is_payload
	logic                  m_tlast;        // frame_done
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// parser state as the testbench expects it
	logic [3:0]  phase = PH_IDLE;
	logic [31:0] hdr_bytes = '0;
	logic [7:0]  len_high = '0;
	logic [15:0] pay_len = '0;
	logic [15:0] left_cnt = '0;
	logic [7:0]  dsum = '0;
	logic [7:0]  cfg_cmd = EXP_CMD_RESET;
	logic [15:0] cfg_max = MAX_LEN_RESET;

	nrfp_res_t expected_words[$];
	int        errors = 0;
	int        bytes_parsed = 0;
	int        rx_hold_cycles = 0;
	bit        tx_calm = 1'b0;
	bit        rx_calm = 1'b0;

	nfc_reply_frame_parser_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// frame end word, parser goes back to idle
	function automatic bit close_frame(input logic [3:0] st, input logic [15:0] flen,
			output nrfp_res_t r);
		r = '0;
		r.frame_done = 1'b1;
		r.status = st;
		r.frame_length = flen;
		phase = PH_IDLE;
		return 1'b1;
	endfunction

	// length limits, then on to the type byte
	function automatic bit take_length(input logic [15:0] len_all, output nrfp_res_t r);
		r = '0;
		if (len_all < 16'd2)
			return close_frame(ST_BAD_LEN, '0, r);
		if (len_all - 16'd2 > cfg_max)
			return close_frame(ST_BAD_LEN, len_all - 16'd2, r);
		pay_len = len_all - 16'd2;
		phase = PH_TFI;
		return 1'b0;
	endfunction

	// expected word, if any, for one accepted byte
	function automatic bit parse_reply_byte(input bit is_first, input logic [7:0] b,
			output nrfp_res_t r);
		logic [7:0] prev;
		r = '0;
		if (is_first) begin
			phase = PH_PRE1;
			hdr_bytes = '0;
			len_high = '0;
			pay_len = '0;
			left_cnt = '0;
			dsum = '0;
			if (b != BYTE_ZERO)
				return close_frame(ST_PREAMBLE, '0, r);
			return 1'b0;
		end
		case (phase)
			PH_PRE1: begin
				if (b == BYTE_FF)
					phase = PH_CODE1;
				else if (b == BYTE_ZERO)
					phase = PH_PRE2;
				else
					return close_frame(ST_PREAMBLE, '0, r);
			end
			PH_PRE2: begin
				if (b != BYTE_FF)
					return close_frame(ST_PREAMBLE, '0, r);
				phase = PH_CODE1;
			end
			PH_CODE1: begin
				hdr_bytes = {24'd0, b};
				phase = PH_CODE2;
			end
			PH_CODE2: begin
				prev = hdr_bytes[7:0];
				hdr_bytes = {hdr_bytes[23:0], b};
				if (prev == BYTE_ERR && b == BYTE_FF) begin
					left_cnt = 16'd3;
					phase = PH_ERRF;
				end else if (prev == BYTE_FF && b == BYTE_FF) begin
					phase = PH_EXTH;
				end else if (9'(prev) + 9'(b) != 9'd256) begin
					return close_frame(ST_LEN_CSUM, '0, r);
				end else begin
					return take_length({8'd0, prev}, r);
				end
			end
			PH_ERRF: begin
				left_cnt = left_cnt - 16'd1;
				if (left_cnt == 16'd0)
					return close_frame(ST_ERR_FRAME, '0, r);
			end
			PH_EXTH: begin
				len_high = b;
				phase = PH_EXTL;
			end
			PH_EXTL: begin
				hdr_bytes = {hdr_bytes[23:0], b};
				phase = PH_EXTCS;
			end
			PH_EXTCS: begin
				if (8'(len_high + hdr_bytes[7:0] + b) != 8'd0)
					return close_frame(ST_LEN_CSUM, '0, r);
				return take_length({len_high, hdr_bytes[7:0]}, r);
			end
			PH_TFI: begin
				if (b != BYTE_TYPE)
					return close_frame(ST_TYPE, pay_len, r);
				dsum = BYTE_TYPE;
				phase = PH_CC;
			end
			PH_CC: begin
				// compared at 9 bits, so command 255 never matches
				if ({1'b0, b} != {1'b0, cfg_cmd} + 9'd1)
					return close_frame(ST_RESP_CODE, pay_len, r);
				dsum = dsum + b;
				if (pay_len == 16'd0) begin
					phase = PH_DCS;
				end else begin
					left_cnt = pay_len;
					phase = PH_DATA;
				end
			end
			PH_DATA: begin
				dsum = dsum + b;
				left_cnt = left_cnt - 16'd1;
				if (left_cnt == 16'd0)
					phase = PH_DCS;
				r.is_payload = 1'b1;
				r.payload_byte = b;
				return 1'b1;
			end
			PH_DCS: begin
				if (8'(dsum + b) != 8'd0)
					return close_frame(ST_DATA_CSUM, pay_len, r);
				phase = PH_POST;
			end
			PH_POST: begin
				return close_frame((b == BYTE_ZERO) ? ST_OK : ST_POSTAMBLE, pay_len, r);
			end
			default: phase = PH_IDLE; // idle bytes are dropped
		endcase
		return 1'b0;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 100)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	// one byte word on the slave side, with a random gap before it
	task automatic send_byte(input bit is_first, input logic [7:0] b);
		int gap;
		nrfp_res_t r;
		gap = tx_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= is_first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (is_first || phase != PH_IDLE)
			bytes_parsed++;
		if (parse_reply_byte(is_first, b, r))
			expected_words.push_back(r);
	endtask

	// bytes of one frame, stopping once the frame has ended
	task automatic send_frame_bytes(input logic [7:0] fb[$]);
		foreach (fb[i]) begin
			send_byte(i == 0, fb[i]);
			if (phase == PH_IDLE)
				break;
		end
	endtask

	// build and send one reply frame, optionally broken in one place
	task automatic send_reply(input logic [15:0] len_all, input bit ext, input bit long_pre,
			input flaw_t flaw);
		logic [7:0] fb[$];
		logic [7:0] lcs;
		logic [7:0] code;
		logic [7:0] csum;
		logic [7:0] b;
		int unsigned plen;
		fb.push_back(BYTE_ZERO);
		if (long_pre)
			fb.push_back(BYTE_ZERO);
		fb.push_back(BYTE_FF);
		if (ext) begin
			lcs = 8'd0 - len_all[15:8] - len_all[7:0];
			fb.push_back(BYTE_FF);
			fb.push_back(BYTE_FF);
			fb.push_back(len_all[15:8]);
			fb.push_back(len_all[7:0]);
		end else begin
			lcs = 8'd0 - len_all[7:0];
			fb.push_back(len_all[7:0]);
		end
		if (flaw == FL_LCS)
			lcs = lcs ^ 8'($urandom_range(1, 255));
		fb.push_back(lcs);
		code = cfg_cmd + 8'd1;
		if (flaw == FL_CODE)
			code = code ^ 8'($urandom_range(1, 255));
		fb.push_back((flaw == FL_TYPE) ? (BYTE_TYPE ^ 8'($urandom_range(1, 255))) : BYTE_TYPE);
		fb.push_back(code);
		csum = BYTE_TYPE + code;
		// no payload needed where the frame ends before it
		plen = (len_all >= 16'd2 && len_all - 16'd2 <= cfg_max && flaw != FL_TYPE &&
			flaw != FL_CODE) ? 32'(len_all - 16'd2) : 0;
		repeat (plen) begin
			b = 8'($urandom);
			csum = csum + b;
			fb.push_back(b);
		end
		csum = 8'd0 - csum;
		if (flaw == FL_DCS)
			csum = csum ^ 8'($urandom_range(1, 255));
		fb.push_back(csum);
		fb.push_back((flaw == FL_POST) ? 8'($urandom_range(1, 255)) : BYTE_ZERO);
		send_frame_bytes(fb);
	endtask

	// stop sending and wait until every expected word is out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one apb transfer, setup then access, then back to idle
	task automatic apb_access(input bit wr, input logic idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(input logic idx, input logic [31:0] want);
		logic [31:0] rd;
		apb_access(1'b0, idx, '0, rd);
		check_field("register read", want, rd);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] val);
		logic [31:0] rd;
		drain();
		if (idx == REG_EXP_CMD)
			cfg_cmd = val[7:0];
		else
			cfg_max = val[15:0];
		apb_access(1'b1, idx, val, rd);
		reg_check(idx, (idx == REG_EXP_CMD) ? {24'd0, val[7:0]} : {16'd0, val[15:0]});
	endtask

	task automatic test_reset_values();
		reg_check(REG_EXP_CMD, {24'd0, EXP_CMD_RESET});
		reg_check(REG_MAX_LEN, {16'd0, MAX_LEN_RESET});
	endtask

	task automatic test_good_frames();
		send_reply(16'd2, 1'b0, 1'b0, FL_NONE);
		send_reply(16'd5, 1'b0, 1'b1, FL_NONE);
		send_reply(16'd4, 1'b1, 1'b0, FL_NONE);
		send_reply(16'd2, 1'b1, 1'b1, FL_NONE);
	endtask

	task automatic test_header_errors();
		logic [7:0] fb[$];
		// preamble broken at each position
		fb = {8'h5A};
		send_frame_bytes(fb);
		fb = {BYTE_ZERO, 8'h12};
		send_frame_bytes(fb);
		fb = {BYTE_ZERO, BYTE_ZERO, 8'h12};
		send_frame_bytes(fb);
		fb = {BYTE_ZERO, BYTE_ZERO, BYTE_ZERO};
		send_frame_bytes(fb);
		// error frame
		fb = {BYTE_ZERO, BYTE_FF, BYTE_ERR, BYTE_FF, 8'h7F, 8'h81, BYTE_ZERO};
		send_frame_bytes(fb);
		// length checksum, short and too long lengths
		send_reply(16'd6, 1'b0, 1'b0, FL_LCS);
		send_reply(16'd6, 1'b1, 1'b0, FL_LCS);
		send_reply(16'd0, 1'b0, 1'b0, FL_NONE);
		send_reply(16'd1, 1'b0, 1'b0, FL_NONE);
		send_reply(16'd0, 1'b1, 1'b0, FL_NONE);
		send_reply(16'd1, 1'b1, 1'b1, FL_NONE);
		send_reply(16'd267, 1'b1, 1'b1, FL_NONE);
		// largest accepted length, stopped at the type byte
		send_reply(16'd266, 1'b1, 1'b0, FL_TYPE);
	endtask

	task automatic test_body_errors();
		send_reply(16'd5, 1'b0, 1'b0, FL_TYPE);
		send_reply(16'd5, 1'b0, 1'b1, FL_CODE);
		send_reply(16'd5, 1'b0, 1'b0, FL_DCS);
		send_reply(16'd5, 1'b0, 1'b0, FL_POST);
		send_reply(16'd3, 1'b1, 1'b0, FL_DCS);
	endtask

	task automatic test_restart_and_idle();
		logic [7:0] fb[$];
		// frame cut off in its payload, then a fresh frame
		fb = {BYTE_ZERO, BYTE_FF, 8'h07, 8'hF9, BYTE_TYPE, 8'h01, 8'hAA};
		send_frame_bytes(fb);
		send_reply(16'd3, 1'b0, 1'b0, FL_NONE);
		// bytes outside a frame
		send_byte(1'b0, BYTE_FF);
		send_byte(1'b0, BYTE_ZERO);
		send_byte(1'b0, 8'($urandom));
		send_reply(16'd2, 1'b0, 1'b1, FL_NONE);
	endtask

	task automatic test_command_limits();
		reg_write(REG_EXP_CMD, 32'd255);
		send_reply(16'd4, 1'b0, 1'b0, FL_NONE);
		send_reply(16'd4, 1'b1, 1'b0, FL_NONE);
		reg_write(REG_EXP_CMD, 32'h4A);
		send_reply(16'd4, 1'b0, 1'b0, FL_NONE);
		send_reply(16'd4, 1'b0, 1'b0, FL_CODE);
	endtask

	task automatic test_length_limits();
		reg_write(REG_MAX_LEN, 32'd0);
		send_reply(16'd2, 1'b0, 1'b0, FL_NONE);
		send_reply(16'd3, 1'b0, 1'b0, FL_NONE);
		reg_write(REG_MAX_LEN, 32'd65533);
		send_reply(16'hFFFF, 1'b1, 1'b0, FL_TYPE);
		send_reply(16'd255, 1'b0, 1'b0, FL_TYPE);
		reg_write(REG_MAX_LEN, {16'd0, MAX_LEN_RESET});
	endtask

	// receiver holds off while the sender keeps going, then a full pause
	task automatic test_backpressure();
		tx_calm = 1'b1;
		rx_hold_cycles = 300;
		send_reply(16'd42, 1'b0, 1'b0, FL_NONE);
		tx_calm = 1'b0;
		drain();
	endtask

	task automatic test_random_traffic();
		logic [7:0] fb[$];
		int target;
		int pick;
		int n;
		int plen;
		bit ext;
		flaw_t flaw;
		// run total of parsed bytes
		target = 700;
		while (bytes_parsed < target) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// well-formed frame shape with random content
				ext = ($urandom_range(0, 3) == 0);
				n = $urandom_range(0, 19);
				plen = (n < 16) ? $urandom_range(0, 12) :
					(n < 19) ? $urandom_range(13, 40) : $urandom_range(100, 253);
				flaw = ($urandom_range(0, 9) < 7) ? FL_NONE : flaw_t'($urandom_range(1, 5));
				send_reply(16'(plen + 2), ext, 1'($urandom_range(0, 1)), flaw);
			end else if (pick < 73) begin
				// extended header with any length
				send_reply(16'($urandom), 1'b1, 1'($urandom_range(0, 1)), FL_TYPE);
			end else if (pick < 82) begin
				// frame start followed by random header bytes
				send_byte(1'b1, BYTE_ZERO);
				repeat ($urandom_range(1, 5)) send_byte(1'b0, 8'($urandom));
			end else if (pick < 92) begin
				// noise, with stray frame starts
				repeat ($urandom_range(1, 6))
					send_byte($urandom_range(0, 3) == 0, 8'($urandom));
			end else begin
				fb = {BYTE_ZERO, BYTE_FF, BYTE_ERR, BYTE_FF,
					8'($urandom), 8'($urandom), 8'($urandom)};
				send_frame_bytes(fb);
			end
			// occasional pause and new register settings
			n = $urandom_range(0, 29);
			if (n == 0) begin
				drain();
			end else if (n == 1) begin
				reg_write(REG_EXP_CMD, ($urandom_range(0, 3) == 0) ? 32'd255 : $urandom_range(0, 255));
			end else if (n == 2) begin
				case ($urandom_range(0, 3))
					0: reg_write(REG_MAX_LEN, $urandom_range(0, 8));
					1: reg_write(REG_MAX_LEN, {16'd0, MAX_LEN_RESET});
					2: reg_write(REG_MAX_LEN, 32'd65533);
					default: reg_write(REG_MAX_LEN, $urandom_range(9, 300));
				endcase
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// master side ready, random stall per word plus requested long hold-offs
	initial begin : rx_side
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 17);
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin : check_words
		nrfp_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 100)
					$display("%0t: unexpected word, expected none, got tdata %h tuser %b tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
			end else begin
				want = expected_words.pop_front();
				check_field("is_payload", 32'(want.is_payload), 32'(m_tuser));
				check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
				check_field("frame_done", 32'(want.frame_done), 32'(m_tlast));
				check_field("status", 32'(want.status), 32'(m_tdata[11:8]));
				check_field("frame_length", 32'(want.frame_length), 32'(m_tdata[27:12]));
				check_field("tdata padding", '0, 32'(m_tdata[31:28]));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_good_frames();
		test_header_errors();
		test_body_errors();
		test_restart_and_idle();
		test_command_limits();
		test_length_limits();
		test_backpressure();
		test_random_traffic();
		drain();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
